// ===== rtl/pnoise2d_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the 2D gradient noise evaluator.
// No dependencies; imported by perlin_noise_2d_eval_core.
package pnoise2d_pkg;

   localparam int unsigned FRAC_BITS  = 16;
   localparam int unsigned TABLE_SIZE = 256;
   localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
   localparam int unsigned COORD_W    = 24;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned NOISE_W    = 16;

   // req tdata: table_index, table_value, x_coord, y_coord
   localparam int unsigned REQ_DATA_W = 2 * BYTE_W + 2 * COORD_W;
   localparam int unsigned RSP_DATA_W = NOISE_W;

   // (n + 1) / 2 rescale from Q.FRAC_BITS to Q0.16
   localparam int unsigned OUT_SHIFT  = FRAC_BITS + 1 - NOISE_W;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   // low two hash bits pick the diagonal gradient
   typedef enum logic [1:0] {
      GRAD_PP = 2'd0,   //  x + y
      GRAD_NP = 2'd1,   // -x + y
      GRAD_PN = 2'd2,   //  x - y
      GRAD_NN = 2'd3    // -x - y
   } grad_type;

endpackage

// ===== rtl/perlin_noise_2d_eval_core.sv =====
`timescale 1ns / 1ps
// 2D gradient noise evaluator: permutation table in three mirrored RAMs,
// two-level hash, quintic fade and bilinear blend in an 8-stage pipeline.
// Depends on pnoise2d_pkg.
//
//   channel  dir  tuser      tdata                                          
//   req_*    in   op         table_index, table_value, x_coord, y_coord
//   rsp_*    out  -          noise
//
// One transaction per cycle in steady state while the skid entry stays empty.
// The rate is set by the table lookups: each
// evaluate needs six reads, served by three mirrored copies of the table
// with two read ports each. A load writes all copies in its accept cycle.
// Reset clears only the pipeline, output and skid valid bits; the table holds
// garbage until loaded. A stalled output fills a one-entry skid register,
// and req_tready drops only while that skid entry is occupied.
module perlin_noise_2d_eval_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] table_index, [15:8] table_value, [39:16] x_coord, [63:40] y_coord
   input  logic [pnoise2d_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] op
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] noise
   output logic [pnoise2d_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import pnoise2d_pkg::*;

   localparam int unsigned FW = 22;   // fade linear term
   localparam logic signed [FW-1:0] C15 = FW'(15 << FRAC_BITS);
   localparam logic [20:0]          C10 = 21'(10 << FRAC_BITS);
   localparam logic [16:0]          ONE_U = 17'(1 << FRAC_BITS);
   localparam logic signed [17:0]   ONE_S = 18'sd1 <<< FRAC_BITS;
   localparam logic [43:0]          HALF = 44'd1 << (FRAC_BITS - 1);
   localparam logic [24:0]          OUT_RND = 25'd1 << (OUT_SHIFT - 1);
   localparam logic signed [25:0]   NOISE_MAX = 26'((1 << NOISE_W) - 1);

   // -------------------------------------------------------------------
   // handshake and field split
   logic adv;
   logic req_acc;
   logic skid_vld_ff, skid_vld_in;
   logic out_vld_ff, out_vld_in;
   logic [NOISE_W-1:0] out_ff, out_in, skid_ff, skid_in;

   logic [BYTE_W-1:0]    tbl_idx, tbl_val;
   logic [COORD_W-1:0]   x_coord, y_coord;
   op_type               op;
   logic [IDX_W-1:0]     ix, ix1, iy;
   logic [FRAC_BITS-1:0] fx, fy;

   assign adv        = !skid_vld_ff;
   assign req_tready = adv;
   assign req_acc    = req_tvalid && adv;

   assign tbl_idx = req_tdata[BYTE_W-1:0];
   assign tbl_val = req_tdata[2*BYTE_W-1:BYTE_W];
   assign x_coord = req_tdata[2*BYTE_W+COORD_W-1:2*BYTE_W];
   assign y_coord = req_tdata[2*BYTE_W+2*COORD_W-1:2*BYTE_W+COORD_W];
   assign op      = op_type'(req_tuser);

   assign ix  = x_coord[COORD_W-1:FRAC_BITS];
   assign iy  = y_coord[COORD_W-1:FRAC_BITS];
   assign ix1 = ix + IDX_W'(1);
   assign fx  = x_coord[FRAC_BITS-1:0];
   assign fy  = y_coord[FRAC_BITS-1:0];

   logic tbl_we;
   assign tbl_we = req_acc && (op == OP_LOAD);

   // -------------------------------------------------------------------
   // permutation table: three mirrors, read-before-write on each
   logic [BYTE_W-1:0] perm_a [TABLE_SIZE];
   logic [BYTE_W-1:0] perm_b [TABLE_SIZE];
   logic [BYTE_W-1:0] perm_c [TABLE_SIZE];

   logic [BYTE_W-1:0] l1a_ff, l1b_ff;            // perm[ix], perm[ix+1]
   logic [BYTE_W-1:0] h00_ff, h01_ff, h10_ff, h11_ff;
   logic [IDX_W-1:0]  iy_ff, iy1_in;
   logic [IDX_W-1:0]  a00_in, a01_in, a10_in, a11_in;

   assign iy1_in = iy_ff + IDX_W'(1);
   assign a00_in = IDX_W'(l1a_ff) + iy_ff;
   assign a01_in = IDX_W'(l1a_ff) + iy1_in;
   assign a10_in = IDX_W'(l1b_ff) + iy_ff;
   assign a11_in = IDX_W'(l1b_ff) + iy1_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         l1a_ff <= perm_a[ix];
         l1b_ff <= perm_a[ix1];
         if (tbl_we) begin
            perm_a[IDX_W'(tbl_idx)] <= tbl_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h00_ff <= perm_b[a00_in];
         h01_ff <= perm_b[a01_in];
         if (tbl_we) begin
            perm_b[IDX_W'(tbl_idx)] <= tbl_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h10_ff <= perm_c[a10_in];
         h11_ff <= perm_c[a11_in];
         if (tbl_we) begin
            perm_c[IDX_W'(tbl_idx)] <= tbl_val;
         end
      end
   end

   // -------------------------------------------------------------------
   // valid bits, one per stage (evaluate transactions only)
   logic [7:1] vld_ff, vld_in;
   assign vld_in = {vld_ff[6:1], req_acc && (op == OP_EVAL)};

   // -------------------------------------------------------------------
   // stage 0 -> 1: fade first products
   logic signed [FW-1:0] fxs, fys, fax, fay;
   logic signed [43:0]   pax_in, pay_in, pax_ff, pay_ff;
   logic [31:0]          pt2x_in, pt2y_in, pt2x_ff, pt2y_ff;
   logic [FRAC_BITS-1:0] fx1_ff, fy1_ff, fx2_ff, fy2_ff;

   assign fxs     = signed'(FW'(fx));
   assign fys     = signed'(FW'(fy));
   assign fax     = fxs * FW'(6) - C15;
   assign fay     = fys * FW'(6) - C15;
   assign pax_in  = 44'(fax) * 44'(fxs);
   assign pay_in  = 44'(fay) * 44'(fys);
   assign pt2x_in = 32'(fx) * 32'(fx);
   assign pt2y_in = 32'(fy) * 32'(fy);

   // stage 1 -> 2: b = t(6t-15)+10, t^3 partial
   logic signed [43:0] rax, ray;
   logic [31:0]        s2x, s2y, pt3x_in, pt3y_in, pt3x_ff, pt3y_ff;
   logic [20:0]        bx_in, by_in, bx_ff, by_ff;

   assign rax     = pax_ff + signed'(HALF);
   assign ray     = pay_ff + signed'(HALF);
   assign bx_in   = 21'(rax[43:FRAC_BITS]) + C10;
   assign by_in   = 21'(ray[43:FRAC_BITS]) + C10;
   assign s2x     = pt2x_ff + 32'(HALF);
   assign s2y     = pt2y_ff + 32'(HALF);
   assign pt3x_in = 32'(s2x[31:FRAC_BITS]) * 32'(fx1_ff);
   assign pt3y_in = 32'(s2y[31:FRAC_BITS]) * 32'(fy1_ff);

   // stage 2 -> 3: t^3 * b; gradients
   logic [31:0] s3x, s3y;
   logic [36:0] pux_in, puy_in, pux_ff, puy_ff;

   assign s3x    = pt3x_ff + 32'(HALF);
   assign s3y    = pt3y_ff + 32'(HALF);
   assign pux_in = 37'(s3x[31:FRAC_BITS]) * 37'(bx_ff);
   assign puy_in = 37'(s3y[31:FRAC_BITS]) * 37'(by_ff);

   function automatic logic signed [18:0] grad(input logic [1:0] h,
                                               input logic signed [17:0] dx,
                                               input logic signed [17:0] dy);
      logic signed [18:0] x, y, g;
      x = 19'(dx);
      y = 19'(dy);
      unique case (grad_type'(h))
         GRAD_PP: g = x + y;
         GRAD_NP: g = y - x;
         GRAD_PN: g = x - y;
         GRAD_NN: g = -x - y;
         default: g = x + y;
      endcase
      return g;
   endfunction

   logic signed [17:0] dx0, dx1, dy0, dy1;
   logic signed [18:0] g1_in, g2_in, g3_in, g4_in;
   logic signed [18:0] g1_ff, g2_ff, g3_ff, g4_ff;

   assign dx0   = signed'(18'(fx2_ff));
   assign dy0   = signed'(18'(fy2_ff));
   assign dx1   = dx0 - ONE_S;
   assign dy1   = dy0 - ONE_S;
   assign g1_in = grad(h00_ff[1:0], dx0, dy0);
   assign g2_in = grad(h10_ff[1:0], dx1, dy0);
   assign g3_in = grad(h01_ff[1:0], dx0, dy1);
   assign g4_in = grad(h11_ff[1:0], dx1, dy1);

   // stage 3 -> 4: fade result clamped to [0, 1]; edge differences
   logic [36:0]        sux, suy;
   logic [16:0]        u_in, v_in, u_ff, v4_ff, v5_ff, v6_ff;
   logic signed [19:0] d12_in, d34_in, d12_ff, d34_ff;
   logic signed [18:0] g1_4_ff, g3_4_ff, g1_5_ff, g3_5_ff;

   assign sux    = pux_ff + 37'(HALF);
   assign suy    = puy_ff + 37'(HALF);
   assign u_in   = (sux[36:FRAC_BITS] > 21'(ONE_U)) ? ONE_U : sux[FRAC_BITS+16:FRAC_BITS];
   assign v_in   = (suy[36:FRAC_BITS] > 21'(ONE_U)) ? ONE_U : suy[FRAC_BITS+16:FRAC_BITS];
   assign d12_in = 20'(g2_ff) - 20'(g1_ff);
   assign d34_in = 20'(g4_ff) - 20'(g3_ff);

   // stage 4 -> 5: weight * difference along x
   logic signed [17:0] us, vs;
   logic signed [37:0] p1_in, p2_in, p1_ff, p2_ff;

   assign us    = signed'({1'b0, u_ff});
   assign p1_in = 38'(us) * 38'(d12_ff);
   assign p2_in = 38'(us) * 38'(d34_ff);

   // stage 5 -> 6: x blends
   logic signed [37:0] r1, r2;
   logic signed [20:0] v1_in, v2_in, v1_ff, v2_ff, v1_7_ff;

   assign r1    = p1_ff + signed'(38'(HALF));
   assign r2    = p2_ff + signed'(38'(HALF));
   assign v1_in = 21'(g1_5_ff) + 21'(signed'(r1[37:FRAC_BITS]));
   assign v2_in = 21'(g3_5_ff) + 21'(signed'(r2[37:FRAC_BITS]));

   // stage 6 -> 7: weight * difference along y
   logic signed [21:0] dv;
   logic signed [39:0] pn_in, pn_ff;

   assign vs    = signed'({1'b0, v6_ff});
   assign dv    = 22'(v2_ff) - 22'(v1_ff);
   assign pn_in = 40'(vs) * 40'(dv);

   // stage 7: final blend, (n+1)/2 rounding and saturation
   logic signed [39:0] rn;
   logic signed [24:0] n_full, m_full;
   logic signed [25:0] m_sh;
   logic [NOISE_W-1:0] noise;

   assign rn     = pn_ff + signed'(40'(HALF));
   assign n_full = 25'(v1_7_ff) + 25'(signed'(rn[39:FRAC_BITS]));
   assign m_full = n_full + 25'(ONE_S) + signed'(OUT_RND);
   assign m_sh   = 26'(m_full) >>> OUT_SHIFT;

   always_comb begin
      if (m_sh < 26'sd0) begin
         noise = '0;
      end else if (m_sh > NOISE_MAX) begin
         noise = '1;
      end else begin
         noise = m_sh[NOISE_W-1:0];
      end
   end

   // -------------------------------------------------------------------
   // pipeline payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         iy_ff   <= iy;
         fx1_ff  <= fx;
         fy1_ff  <= fy;
         pax_ff  <= pax_in;
         pay_ff  <= pay_in;
         pt2x_ff <= pt2x_in;
         pt2y_ff <= pt2y_in;

         fx2_ff  <= fx1_ff;
         fy2_ff  <= fy1_ff;
         bx_ff   <= bx_in;
         by_ff   <= by_in;
         pt3x_ff <= pt3x_in;
         pt3y_ff <= pt3y_in;

         pux_ff  <= pux_in;
         puy_ff  <= puy_in;
         g1_ff   <= g1_in;
         g2_ff   <= g2_in;
         g3_ff   <= g3_in;
         g4_ff   <= g4_in;

         u_ff    <= u_in;
         v4_ff   <= v_in;
         d12_ff  <= d12_in;
         d34_ff  <= d34_in;
         g1_4_ff <= g1_ff;
         g3_4_ff <= g3_ff;

         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         g1_5_ff <= g1_4_ff;
         g3_5_ff <= g3_4_ff;
         v5_ff   <= v4_ff;

         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         v6_ff   <= v5_ff;

         pn_ff   <= pn_in;
         v1_7_ff <= v1_ff;
      end
   end

   // -------------------------------------------------------------------
   // output register plus skid entry
   logic last_vld;
   assign last_vld = vld_ff[7] && adv;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (!out_vld_ff || rsp_tready) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in = last_vld;
            out_in     = noise;
         end
      end else if (last_vld) begin
         skid_vld_in = 1'b1;
         skid_in     = noise;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff <= vld_in;
         end
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

endmodule

// ===== test/perlin_noise_2d_eval_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for perlin_noise_2d_eval_core: table loads and noise evaluations
// checked against an in-bench fixed-point noise predictor. Depends on pnoise2d_pkg.
module perlin_noise_2d_eval_core_tb;
   import pnoise2d_pkg::*;

   localparam longint ONE_Q       = longint'(1) << FRAC_BITS;
   localparam int     CYCLE_LIMIT = 200000;
   localparam int     EXP_DEPTH   = 64;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Shadow copy of the permutation table and the noise values still in flight
   logic [BYTE_W-1:0]     perm_shadow [TABLE_SIZE];
   logic [NOISE_W-1:0]    noise_expected [EXP_DEPTH];
   int                    exp_wr      = 0;
   int                    exp_rd      = 0;
   logic [NOISE_W-1:0]    noise_want;
   int                    mismatches  = 0;
   int                    cycle_count = 0;
   int                    stall_left  = 0;
   bit                    pace_random = 1'b1;

   perlin_noise_2d_eval_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- noise predictor
   // Q product, rounded to nearest with ties toward +inf
   function automatic longint q_mul(input longint a, input longint b);
      return (a * b + (ONE_Q >>> 1)) >>> FRAC_BITS;
   endfunction

   // quintic 6t^5 - 15t^4 + 10t^3, clamped to [0, 1]
   function automatic longint fade_weight(input longint t);
      longint w;
      w = q_mul(q_mul(q_mul(t, t), t), q_mul(t, t * 6 - 15 * ONE_Q) + 10 * ONE_Q);
      if (w < 0)
         w = 0;
      if (w > ONE_Q)
         w = ONE_Q;
      return w;
   endfunction

   function automatic longint grad_dot(input logic [BYTE_W-1:0] h,
                                       input longint dx, input longint dy);
      case (grad_type'(h[1:0]))
         GRAD_PP: return dx + dy;
         GRAD_NP: return -dx + dy;
         GRAD_PN: return dx - dy;
         default: return -dx - dy;
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] lattice_hash(input logic [IDX_W-1:0] ix,
                                                      input logic [IDX_W-1:0] iy);
      logic [IDX_W-1:0] second;
      second = perm_shadow[ix] + iy;   // wraps at the table size
      return perm_shadow[second];
   endfunction

   function automatic longint lerp_q(input longint a, input longint b, input longint w);
      return a + q_mul(w, b - a);
   endfunction

   function automatic logic [NOISE_W-1:0] noise_at(input logic [COORD_W-1:0] xc,
                                                   input logic [COORD_W-1:0] yc);
      logic [IDX_W-1:0] ix, iy, ix1, iy1;
      longint fx, fy, u, v, g1, g2, g3, g4, row0, row1, n, m;
      ix  = xc[FRAC_BITS +: IDX_W];
      iy  = yc[FRAC_BITS +: IDX_W];
      ix1 = ix + 1'b1;
      iy1 = iy + 1'b1;
      fx  = longint'(xc[FRAC_BITS-1:0]);
      fy  = longint'(yc[FRAC_BITS-1:0]);
      u   = fade_weight(fx);
      v   = fade_weight(fy);
      g1  = grad_dot(lattice_hash(ix, iy), fx, fy);
      g2  = grad_dot(lattice_hash(ix1, iy), fx - ONE_Q, fy);
      g3  = grad_dot(lattice_hash(ix, iy1), fx, fy - ONE_Q);
      g4  = grad_dot(lattice_hash(ix1, iy1), fx - ONE_Q, fy - ONE_Q);
      row0 = lerp_q(g1, g2, u);
      row1 = lerp_q(g3, g4, u);
      n    = lerp_q(row0, row1, v);
      // (n + 1) / 2 into Q0.16
      m = n + ONE_Q;
      if (OUT_SHIFT > 0)
         m = (m + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      if (m < 0)
         m = 0;
      if (m > 65535)
         m = 65535;
      return m[NOISE_W-1:0];
   endfunction

   // ---------------------------------------------------------------- request side
   task automatic send_item(input op_type op, input logic [BYTE_W-1:0] tbl_idx,
                            input logic [BYTE_W-1:0] tbl_val,
                            input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      int gap;
      if (pace_random && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {y, x, tbl_val, tbl_idx};
      do @(posedge clock); while (!req_tready);
      // transaction accepted at this edge
      if (op == OP_LOAD)
         perm_shadow[tbl_idx[IDX_W-1:0]] = tbl_val;
      else begin
         noise_expected[exp_wr % EXP_DEPTH] = noise_at(x, y);
         exp_wr++;
      end
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (exp_rd != exp_wr);
   endtask

   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return {8'($urandom), 16'h0000};
         1: return {8'hFF, 16'($urandom)};
         2: return {8'($urandom), 16'hFFFF};
         3: return {8'($urandom), 16'h8000};
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // every entry must be written before the first evaluate
   task automatic load_table_test();
      logic [BYTE_W-1:0] shuffled [TABLE_SIZE];
      logic [BYTE_W-1:0] tmp;
      int j;
      for (int i = 0; i < TABLE_SIZE; i++)
         shuffled[i] = BYTE_W'(i);
      for (int i = TABLE_SIZE - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = shuffled[i];
         shuffled[i] = shuffled[j];
         shuffled[j] = tmp;
      end
      for (int i = 0; i < TABLE_SIZE; i++)
         send_item(OP_LOAD, BYTE_W'(i), shuffled[i], COORD_W'($urandom), COORD_W'($urandom));
   endtask

   task automatic corner_cases_test();
      // load fields at their extremes
      send_item(OP_LOAD, 8'hFF, 8'hFF, 24'hFFFFFF, 24'hFFFFFF);
      send_item(OP_LOAD, 8'h00, 8'h00, 24'h000000, 24'h000000);
      // lattice edges and fraction extremes
      send_item(OP_EVAL, 8'hFF, 8'hFF, 24'h000000, 24'h000000);
      send_item(OP_EVAL, 8'h00, 8'h00, 24'hFFFFFF, 24'hFFFFFF);
      send_item(OP_EVAL, 8'hA5, 8'h5A, 24'hFF0000, 24'hFF0000);
      send_item(OP_EVAL, 8'h00, 8'hFF, 24'h00FFFF, 24'hFF8000);
      send_item(OP_EVAL, 8'hFF, 8'h00, 24'h7FFFFF, 24'h800000);
      send_item(OP_EVAL, 8'h3C, 8'hC3, 24'hFFFFFF, 24'h000000);
      // cell (10,20): all four diagonals point at the center, n = +1 saturates
      send_item(OP_LOAD, 8'd10, 8'd10, 24'h0, 24'h0);
      send_item(OP_LOAD, 8'd11, 8'd100, 24'h0, 24'h0);
      send_item(OP_LOAD, 8'd30, 8'(GRAD_PP), 24'h0, 24'h0);
      send_item(OP_LOAD, 8'd120, 8'(GRAD_NP), 24'h0, 24'h0);
      send_item(OP_LOAD, 8'd31, 8'(GRAD_PN), 24'h0, 24'h0);
      send_item(OP_LOAD, 8'd121, 8'(GRAD_NN), 24'h0, 24'h0);
      send_item(OP_EVAL, 8'h00, 8'h00, 24'h0A8000, 24'h148000);
      // same cell, all pointing away: n = -1 floors at zero
      send_item(OP_LOAD, 8'd30, 8'(GRAD_NN), 24'h0, 24'h0);
      send_item(OP_LOAD, 8'd120, 8'(GRAD_PN), 24'h0, 24'h0);
      send_item(OP_LOAD, 8'd31, 8'(GRAD_NP), 24'h0, 24'h0);
      send_item(OP_LOAD, 8'd121, 8'(GRAD_PP), 24'h0, 24'h0);
      send_item(OP_EVAL, 8'h00, 8'h00, 24'h0A8000, 24'h148000);
   endtask

   task automatic random_mix_test(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0)
            send_item(OP_LOAD, BYTE_W'($urandom), BYTE_W'($urandom),
                      COORD_W'($urandom), COORD_W'($urandom));
         else
            send_item(OP_EVAL, BYTE_W'($urandom), BYTE_W'($urandom),
                      rand_coord(), rand_coord());
      end
   endtask

   // ---------------------------------------------------------------- response side
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= (stall_left == 0);
      end else if (pace_random && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (exp_rd == exp_wr) begin
            mismatches++;
            $display("%0t: unexpected noise transaction, expected none, actual %h",
                     $time, rsp_tdata);
         end else begin
            noise_want = noise_expected[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_tdata !== noise_want) begin
               mismatches++;
               $display("%0t: noise mismatch, expected %h, actual %h",
                        $time, noise_want, rsp_tdata);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      load_table_test();
      corner_cases_test();
      // hold off until the pipeline has emptied, then resume
      wait_results_drained();
      random_mix_test(230);
      // last stretch at full rate on both sides
      pace_random = 1'b0;
      random_mix_test(100);
      wait_results_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
